// ===== rtl/qtp_pkg.sv =====
// Shared types, constants and codes of the QP-table container parser.
package qtp_pkg;

   // Limits of the container format.
   localparam int MAX_TABLES = 16;
   localparam int NAME_MAX   = 64;
   localparam int MAX_ELEMS  = 1 << 20;

   // Widths that follow from the limits.
   localparam int TABLES_W    = $clog2(MAX_TABLES + 1);
   localparam int NAME_LEFT_W = $clog2(NAME_MAX + 1);

   // Header lengths in bytes.
   localparam logic [31:0] MIN_STREAM_BYTES = 32'd8;
   localparam logic [31:0] FIELD_BYTES      = 32'd4;
   localparam logic [32:0] DIMS_BYTES       = 33'd8;

   // Magic word "QPT1", first byte first.
   localparam logic [7:0] MAGIC [4] = '{8'h51, 8'h50, 8'h54, 8'h31};

   // Depth of the result queue.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_MAGIC,
      PH_COUNT,
      PH_NLEN,
      PH_NAME,
      PH_ROWS,
      PH_COLS,
      PH_ELEM,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NAME    = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_ELEMENT = 2'd2,
      KIND_VERDICT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MAGIC    = 3'd1,
      ST_COUNT    = 3'd2,
      ST_NLEN     = 3'd3,
      ST_NAME     = 3'd4,
      ST_DIMS     = 3'd5,
      ST_ROWS     = 3'd6,
      ST_TRAILING = 3'd7
   } status_type;

   typedef struct packed {
      logic       start_req;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  table_index;
      logic [19:0] position;
      logic [15:0] value;
      logic [20:0] row_count;
      logic [20:0] col_count;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   // Results of one byte, handed from the parser to the result queue.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    rsp0;
      rsp_type    rsp1;
   } push_type;

endpackage

// ===== rtl/qp_table_container_parser.sv =====
// Top level of the QP-table container parser: byte register, parser and result queue.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    start_req, data_byte (one byte per item)
//   rsp      out        rsp_valid/stall    kind, table_index, position, value,
//                                          row_count, col_count, status, last
//   csr      in         csr_valid/ready    stream_size (32 bits)
//
// The block takes one byte item in every cycle while req_stall is low. A taken byte
// is held in the byte register and parsed once the queue has room; its results then
// enter the four-entry result queue. A byte makes at most two results; the parser
// moves on only while the queue has two free entries, and req_stall rises when a
// byte is held and it does not. Reset is synchronous and leaves the parser idle with
// the queue empty. The stream length register is always ready.
module qp_table_container_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qtp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qtp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);
   import qtp_pkg::*;

   logic [31:0] size_ff, size_in;
   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff, in_data_in;
   logic        room;
   logic        fire;
   logic        accept;
   push_type    push;

   // The register port never holds off a write.
   assign csr_ready = 1'b1;

   // The held byte is parsed when both of its results are sure to fit.
   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      size_in     = (csr_valid && csr_ready) ? csr_data : size_ff;
      in_data_in  = accept ? req_data : in_data_ff;
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         size_ff     <= size_in;
         in_valid_ff <= in_valid_in;
      end
   end

   // The byte itself needs no reset; its valid bit guards it.
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   qtp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_data_ff),
      .stream_size (size_ff),
      .push        (push)
   );

   qtp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/qtp_parser.sv =====
// Parser state and the per-byte field logic of the container.
module qtp_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  qtp_pkg::req_type item,
   input  logic [31:0]      stream_size,
   output qtp_pkg::push_type push
);
   import qtp_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [31:0]             field_accum_ff, field_accum_in;
   logic [1:0]              field_byte_pos_ff, field_byte_pos_in;
   logic [31:0]             bytes_left_ff, bytes_left_in;
   logic [TABLES_W-1:0]     tables_total_ff, tables_total_in;
   logic [7:0]              table_number_ff, table_number_in;
   logic [NAME_LEFT_W-1:0]  name_left_ff, name_left_in;
   logic [31:0]             rows_held_ff, rows_held_in;
   logic [20:0]             elements_left_ff, elements_left_in;
   logic [19:0]             element_number_ff, element_number_in;
   logic [7:0]              low_byte_hold_ff, low_byte_hold_in;

   function automatic rsp_type make_rsp(kind_type k, logic [7:0] tbl, logic [19:0] pos,
                                        logic [15:0] val, logic [20:0] rows,
                                        logic [20:0] cols, status_type st);
      rsp_type r;
      r.kind        = k;
      r.table_index = tbl;
      r.position    = pos;
      r.value       = val;
      r.row_count   = rows;
      r.col_count   = cols;
      r.status      = st;
      r.last        = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic [31:0] fld;
      logic        fdone;
      logic [20:0] r21;
      logic [20:0] c21;
      logic [41:0] prod;
      logic        dims_bad;

      phase_in          = phase_ff;
      field_accum_in    = field_accum_ff;
      field_byte_pos_in = field_byte_pos_ff;
      bytes_left_in     = bytes_left_ff;
      tables_total_in   = tables_total_ff;
      table_number_in   = table_number_ff;
      name_left_in      = name_left_ff;
      rows_held_in      = rows_held_ff;
      elements_left_in  = elements_left_ff;
      element_number_in = element_number_ff;
      low_byte_hold_in  = low_byte_hold_ff;
      push              = '0;
      fld               = '0;
      fdone             = 1'b0;
      r21               = '0;
      c21               = '0;
      prod              = '0;
      dims_bad          = 1'b0;

      if (fire) begin
         // A start byte drops all progress and loads the stream length.
         if (item.start_req) begin
            phase_in          = PH_MAGIC;
            field_accum_in    = '0;
            field_byte_pos_in = '0;
            tables_total_in   = '0;
            table_number_in   = '0;
            name_left_in      = '0;
            rows_held_in      = '0;
            elements_left_in  = '0;
            element_number_in = '0;
            low_byte_hold_in  = '0;
            bytes_left_in     = stream_size;
         end

         if (item.start_req && stream_size < MIN_STREAM_BYTES) begin
            push.count = 2'd1;
            push.rsp0  = make_rsp(KIND_VERDICT, 8'd0, '0, '0, '0, '0, ST_MAGIC);
            phase_in   = PH_DONE;
         end else if (phase_in != PH_IDLE && phase_in != PH_DONE) begin
            bytes_left_in = bytes_left_in - 32'd1;
            // Little-endian field with this byte merged in.
            fld   = field_accum_in | ({24'd0, item.data_byte} << {field_byte_pos_in, 3'b000});
            fdone = (field_byte_pos_in == 2'd3);

            case (phase_in)
               PH_MAGIC: begin
                  if (item.data_byte != MAGIC[field_byte_pos_in]) begin
                     push.count = 2'd1;
                     push.rsp0  = make_rsp(KIND_VERDICT, 8'd0, '0, '0, '0, '0, ST_MAGIC);
                     phase_in   = PH_DONE;
                  end else if (fdone) begin
                     field_byte_pos_in = '0;
                     field_accum_in    = '0;
                     phase_in          = PH_COUNT;
                  end else begin
                     field_byte_pos_in = field_byte_pos_in + 2'd1;
                  end
               end
               PH_COUNT: begin
                  field_accum_in    = fld;
                  field_byte_pos_in = field_byte_pos_in + 2'd1;
                  if (fdone) begin
                     if (fld == 32'd0 || fld > 32'(MAX_TABLES)) begin
                        push.count = 2'd1;
                        push.rsp0  = make_rsp(KIND_VERDICT, 8'd0, '0, '0, '0, '0, ST_COUNT);
                        phase_in   = PH_DONE;
                     end else begin
                        tables_total_in = fld[TABLES_W-1:0];
                        table_number_in = '0;
                        field_accum_in  = '0;
                        if (bytes_left_in < FIELD_BYTES) begin
                           push.count = 2'd1;
                           push.rsp0  = make_rsp(KIND_VERDICT, 8'd0, '0, '0, '0, '0,
                                                 ST_NLEN);
                           phase_in   = PH_DONE;
                        end else begin
                           phase_in = PH_NLEN;
                        end
                     end
                  end
               end
               PH_NLEN: begin
                  field_accum_in    = fld;
                  field_byte_pos_in = field_byte_pos_in + 2'd1;
                  if (fdone) begin
                     if (fld == 32'd0 || fld > 32'(NAME_MAX) ||
                         {1'b0, bytes_left_in} < ({1'b0, fld} + DIMS_BYTES)) begin
                        push.count = 2'd1;
                        push.rsp0  = make_rsp(KIND_VERDICT, table_number_in, '0, '0, '0, '0,
                                              ST_NAME);
                        phase_in   = PH_DONE;
                     end else begin
                        name_left_in      = fld[NAME_LEFT_W-1:0];
                        element_number_in = '0;
                        phase_in          = PH_NAME;
                     end
                  end
               end
               PH_NAME: begin
                  push.count        = 2'd1;
                  push.rsp0         = make_rsp(KIND_NAME, table_number_in, element_number_in,
                                               {8'd0, item.data_byte}, '0, '0, ST_OK);
                  element_number_in = element_number_in + 20'd1;
                  name_left_in      = name_left_in - NAME_LEFT_W'(1);
                  if (name_left_in == '0) begin
                     field_accum_in    = '0;
                     field_byte_pos_in = '0;
                     phase_in          = PH_ROWS;
                  end
               end
               PH_ROWS: begin
                  field_accum_in    = fld;
                  field_byte_pos_in = field_byte_pos_in + 2'd1;
                  if (fdone) begin
                     rows_held_in   = fld;
                     field_accum_in = '0;
                     phase_in       = PH_COLS;
                  end
               end
               PH_COLS: begin
                  field_accum_in    = fld;
                  field_byte_pos_in = field_byte_pos_in + 2'd1;
                  if (fdone) begin
                     // Both sides are cut to 21 bits so the product stays 21 by 21.
                     r21      = rows_held_in[20:0];
                     c21      = fld[20:0];
                     prod     = r21 * c21;
                     dims_bad = rows_held_in == 32'd0 || fld == 32'd0 ||
                                rows_held_in > 32'(MAX_ELEMS) || fld > 32'(MAX_ELEMS) ||
                                prod > 42'(MAX_ELEMS);
                     if (dims_bad) begin
                        push.count = 2'd1;
                        push.rsp0  = make_rsp(KIND_VERDICT, table_number_in, '0, '0, '0, '0,
                                              ST_DIMS);
                        phase_in   = PH_DONE;
                     end else if ({1'b0, bytes_left_in} < {10'd0, prod[21:0], 1'b0}) begin
                        push.count = 2'd1;
                        push.rsp0  = make_rsp(KIND_VERDICT, table_number_in, '0, '0, '0, '0,
                                              ST_ROWS);
                        phase_in   = PH_DONE;
                     end else begin
                        push.count        = 2'd1;
                        push.rsp0         = make_rsp(KIND_HEADER, table_number_in, '0, '0,
                                                     r21, c21, ST_OK);
                        elements_left_in  = prod[20:0];
                        element_number_in = '0;
                        field_byte_pos_in = '0;
                        phase_in          = PH_ELEM;
                     end
                  end
               end
               PH_ELEM: begin
                  if (field_byte_pos_in == 2'd0) begin
                     low_byte_hold_in  = item.data_byte;
                     field_byte_pos_in = 2'd1;
                  end else begin
                     field_byte_pos_in = 2'd0;
                     push.count        = 2'd1;
                     push.rsp0         = make_rsp(KIND_ELEMENT, table_number_in,
                                                  element_number_in,
                                                  {item.data_byte, low_byte_hold_in},
                                                  '0, '0, ST_OK);
                     element_number_in = element_number_in + 20'd1;
                     elements_left_in  = elements_left_in - 21'd1;
                     if (elements_left_in == 21'd0) begin
                        if (({1'b0, table_number_in} + 9'd1) < 9'(tables_total_in)) begin
                           table_number_in   = table_number_in + 8'd1;
                           field_accum_in    = '0;
                           field_byte_pos_in = '0;
                           if (bytes_left_in < FIELD_BYTES) begin
                              push.count = 2'd2;
                              push.rsp1  = make_rsp(KIND_VERDICT, table_number_in, '0, '0,
                                                    '0, '0, ST_NLEN);
                              phase_in   = PH_DONE;
                           end else begin
                              phase_in = PH_NLEN;
                           end
                        end else begin
                           push.count = 2'd2;
                           push.rsp1  = make_rsp(KIND_VERDICT, table_number_in, '0, '0,
                                                 '0, '0,
                                                 (bytes_left_in != 32'd0) ? ST_TRAILING
                                                                          : ST_OK);
                           phase_in   = PH_DONE;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         if (push.count == 2'd2) begin
            push.rsp1.last = 1'b1;
         end else if (push.count == 2'd1) begin
            push.rsp0.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         field_accum_ff    <= '0;
         field_byte_pos_ff <= '0;
         bytes_left_ff     <= '0;
         tables_total_ff   <= '0;
         table_number_ff   <= '0;
         name_left_ff      <= '0;
         rows_held_ff      <= '0;
         elements_left_ff  <= '0;
         element_number_ff <= '0;
         low_byte_hold_ff  <= '0;
      end else begin
         phase_ff          <= phase_in;
         field_accum_ff    <= field_accum_in;
         field_byte_pos_ff <= field_byte_pos_in;
         bytes_left_ff     <= bytes_left_in;
         tables_total_ff   <= tables_total_in;
         table_number_ff   <= table_number_in;
         name_left_ff      <= name_left_in;
         rows_held_ff      <= rows_held_in;
         elements_left_ff  <= elements_left_in;
         element_number_ff <= element_number_in;
         low_byte_hold_ff  <= low_byte_hold_in;
      end
   end

endmodule

// ===== rtl/qtp_rsp_queue.sv =====
// Small result queue that takes up to two results a cycle and hands out one while rsp_stall is low.
module qtp_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  qtp_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qtp_pkg::rsp_type  rsp_data
);
   import qtp_pkg::*;

   rsp_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   // Room means two free entries, whatever leaves this cycle.
   assign room      = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      head_in  = pop ? head_ff + QPTR_W'(1) : head_ff;
      tail_in  = tail_ff + QPTR_W'(push.count);
      count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.rsp0;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_ff + QPTR_W'(1)] <= push.rsp1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the QP-table container parser with predictor and scoreboard.
module testbench;
   import qtp_pkg::*;

   // Format limits, kept here so the predictor does not lean on the design's own copy.
   localparam int          TABLE_LIMIT    = 16;
   localparam int          NAME_LIMIT     = 64;
   localparam logic [63:0] ELEM_LIMIT     = 64'd1 << 20;
   // "QPT1" with the first byte on the stream in the lowest byte lane.
   localparam logic [31:0] MAGIC_WORD     = 32'h3154_5051;
   localparam int          ITEM_TARGET    = 1850;
   localparam int          WATCHDOG_LIMIT = 4000;
   // A byte's results pass the byte register and the result queue before they show, so
   // SETTLE_CYCLES spare cycles cover a byte that makes no result at all.
   localparam int          SETTLE_CYCLES  = 6;

   // Ways a generated container departs from a well-formed one.
   typedef enum int {
      FLAW_NONE,
      FLAW_MAGIC,
      FLAW_COUNT,
      FLAW_NLEN,
      FLAW_DIMS,
      FLAW_BIGDIM,
      FLAW_CORRUPT,
      FLAW_NOISE
   } flaw_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data  = '0;

   qp_table_container_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Handshake flags sampled at the rising edge and read by the negedge processes.
   bit      req_fired  = 1'b0;
   bit      rsp_fired  = 1'b0;
   bit      csr_fired  = 1'b0;
   bit      settled    = 1'b0;
   int      idle_pct   = 0;
   int      stall_pct  = 0;
   int      error_count  = 0;
   int      result_count = 0;
   int      parsed_items = 0;
   int      stuck_cycles = 0;

   req_type     byte_queue[$];
   rsp_type     expected_results[$];
   rsp_type     step_results[$];
   rsp_type     expected_rsp;
   logic [7:0]  container_bytes[$];

   // Predictor state: a private copy of the parser's registers.
   logic [31:0] stream_size_reg = '0;
   phase_type   parse_phase     = PH_IDLE;
   logic [31:0] field_word      = '0;
   logic [1:0]  field_pos       = '0;
   logic [31:0] bytes_remaining = '0;
   logic [8:0]  tables_declared = '0;
   logic [7:0]  table_cur       = '0;
   logic [12:0] name_remaining  = '0;
   logic [31:0] rows_latched    = '0;
   logic [20:0] elems_remaining = '0;
   logic [19:0] elem_index      = '0;
   logic [7:0]  low_byte        = '0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want, input int idx);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                   idx, name, got, want));
   endtask

   task automatic add_result(input kind_type k, input logic [7:0] tbl, input logic [19:0] pos,
                             input logic [15:0] val, input logic [20:0] rows,
                             input logic [20:0] cols, input status_type st);
      rsp_type r;
      r.kind        = k;
      r.table_index = tbl;
      r.position    = pos;
      r.value       = val;
      r.row_count   = rows;
      r.col_count   = cols;
      r.status      = st;
      r.last        = 1'b0;
      step_results.insert(step_results.size(), r);
   endtask

   // Every verdict ends the stream; later bytes are ignored until a start.
   task automatic give_verdict(input logic [7:0] tbl, input status_type st);
      add_result(KIND_VERDICT, tbl, 20'd0, 16'd0, 21'd0, 21'd0, st);
      parse_phase = PH_DONE;
   endtask

   // Collects one byte of a little-endian 32-bit field; 1 when the field is whole.
   function automatic bit take_field(input logic [7:0] b);
      field_word = field_word | (32'(b) << (8 * field_pos));
      if (field_pos == 2'd3) begin
         field_pos = 2'd0;
         return 1'b1;
      end
      field_pos = field_pos + 2'd1;
      return 1'b0;
   endfunction

   // A new table needs at least its name length field before the stream runs out.
   task automatic open_table();
      field_word = '0;
      field_pos  = '0;
      if (bytes_remaining < 32'd4)
         give_verdict(table_cur, ST_NLEN);
      else
         parse_phase = PH_NLEN;
   endtask

   // Works out the results of one accepted byte and queues them as expected.
   task automatic parse_byte(input req_type item);
      logic [7:0]  b;
      logic [31:0] word;
      logic [63:0] area;
      bit          active;
      b      = item.data_byte;
      active = 1'b1;
      step_results.delete();
      if (item.start_req) begin
         parse_phase     = PH_MAGIC;
         field_word      = '0;
         field_pos       = '0;
         tables_declared = '0;
         table_cur       = '0;
         name_remaining  = '0;
         rows_latched    = '0;
         elems_remaining = '0;
         elem_index      = '0;
         low_byte        = '0;
         bytes_remaining = stream_size_reg;
         // A stream too short for magic and count fails on its start byte.
         if (stream_size_reg < 32'd8) begin
            give_verdict(8'd0, ST_MAGIC);
            active = 1'b0;
         end
      end else if (parse_phase == PH_IDLE || parse_phase == PH_DONE) begin
         active = 1'b0;
      end
      parsed_items++;
      if (active) begin
         bytes_remaining = bytes_remaining - 32'd1;
         case (parse_phase)
            PH_MAGIC: begin
               if (b != MAGIC_WORD[8 * field_pos +: 8]) begin
                  give_verdict(8'd0, ST_MAGIC);
               end else if (field_pos == 2'd3) begin
                  field_pos   = '0;
                  field_word  = '0;
                  parse_phase = PH_COUNT;
               end else begin
                  field_pos = field_pos + 2'd1;
               end
            end
            PH_COUNT: begin
               if (take_field(b)) begin
                  if (field_word == 0 || field_word > TABLE_LIMIT) begin
                     give_verdict(8'd0, ST_COUNT);
                  end else begin
                     tables_declared = field_word[8:0];
                     table_cur       = '0;
                     open_table();
                  end
               end
            end
            PH_NLEN: begin
               if (take_field(b)) begin
                  word = field_word;
                  // The name and both dimension fields must still fit in the stream.
                  if (word == 0 || word > NAME_LIMIT ||
                      {32'd0, bytes_remaining} < {32'd0, word} + 64'd8) begin
                     give_verdict(table_cur, ST_NAME);
                  end else begin
                     name_remaining = word[12:0];
                     elem_index     = '0;
                     parse_phase    = PH_NAME;
                  end
               end
            end
            PH_NAME: begin
               add_result(KIND_NAME, table_cur, elem_index, {8'h00, b}, 21'd0, 21'd0, ST_OK);
               elem_index     = elem_index + 20'd1;
               name_remaining = name_remaining - 13'd1;
               if (name_remaining == 0) begin
                  field_word  = '0;
                  field_pos   = '0;
                  parse_phase = PH_ROWS;
               end
            end
            PH_ROWS: begin
               if (take_field(b)) begin
                  rows_latched = field_word;
                  field_word   = '0;
                  parse_phase  = PH_COLS;
               end
            end
            PH_COLS: begin
               if (take_field(b)) begin
                  word = field_word;
                  area = {32'd0, rows_latched} * {32'd0, word};
                  if (rows_latched == 0 || word == 0 || area > ELEM_LIMIT) begin
                     give_verdict(table_cur, ST_DIMS);
                  end else if ({32'd0, bytes_remaining} < area * 2) begin
                     give_verdict(table_cur, ST_ROWS);
                  end else begin
                     add_result(KIND_HEADER, table_cur, 20'd0, 16'd0,
                                rows_latched[20:0], word[20:0], ST_OK);
                     elems_remaining = area[20:0];
                     elem_index      = '0;
                     field_pos       = '0;
                     parse_phase     = PH_ELEM;
                  end
               end
            end
            PH_ELEM: begin
               if (field_pos == 2'd0) begin
                  low_byte  = b;
                  field_pos = 2'd1;
               end else begin
                  field_pos = 2'd0;
                  add_result(KIND_ELEMENT, table_cur, elem_index, {b, low_byte},
                             21'd0, 21'd0, ST_OK);
                  elem_index      = elem_index + 20'd1;
                  elems_remaining = elems_remaining - 21'd1;
                  if (elems_remaining == 0) begin
                     if (int'(table_cur) + 1 < int'(tables_declared)) begin
                        table_cur = table_cur + 8'd1;
                        open_table();
                     end else begin
                        give_verdict(table_cur, (bytes_remaining != 0) ? ST_TRAILING : ST_OK);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (step_results.size() != 0) begin
         step_results[step_results.size() - 1].last = 1'b1;
         foreach (step_results[i])
            expected_results.insert(expected_results.size(), step_results[i]);
      end
   endtask

   // Monitor: everything is sampled at the rising edge, before the design's
   // registers move. The predictor runs on each accepted byte and each accepted
   // result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
         rsp_fired = 1'b0;
         csr_fired = 1'b0;
         settled   = 1'b0;
      end else begin
         req_fired = req_valid && !req_stall;
         rsp_fired = rsp_valid && !rsp_stall;
         csr_fired = csr_valid && csr_ready;
         if (csr_fired)
            stream_size_reg = csr_data;
         if (req_fired)
            parse_byte(req_data);
         if (rsp_fired) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_count));
            end else begin
               expected_rsp = expected_results.pop_front();
               check_field("kind", 32'(rsp_data.kind), 32'(expected_rsp.kind),
                           result_count);
               check_field("table_index", 32'(rsp_data.table_index),
                           32'(expected_rsp.table_index), result_count);
               check_field("position", 32'(rsp_data.position), 32'(expected_rsp.position),
                           result_count);
               check_field("value", 32'(rsp_data.value), 32'(expected_rsp.value),
                           result_count);
               check_field("row_count", 32'(rsp_data.row_count),
                           32'(expected_rsp.row_count), result_count);
               check_field("col_count", 32'(rsp_data.col_count),
                           32'(expected_rsp.col_count), result_count);
               check_field("status", 32'(rsp_data.status), 32'(expected_rsp.status),
                           result_count);
               check_field("last", 32'(rsp_data.last), 32'(expected_rsp.last),
                           result_count);
            end
            result_count++;
         end
         // Nothing left to send, nothing on the wire, nothing owed.
         settled = (byte_queue.size() == 0) && (!req_valid || req_fired) &&
                   (expected_results.size() == 0);
      end
   end

   // Driver: inputs change only at the falling edge. A byte stays on the bus
   // until the edge that takes it; the receiver stall is redrawn every cycle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         if (!req_valid || req_fired) begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_data  <= byte_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no handshake at all means a hang.
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic add_byte(input logic [7:0] b);
      container_bytes.insert(container_bytes.size(), b);
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         add_byte(w[8 * i +: 8]);
   endtask

   // Waits until the block has caught up, then lets it finish any byte that
   // makes no result before the caller touches the register or moves on.
   task automatic wait_quiet(input int extra);
      do
         @(negedge clock);
      while (!settled);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_size(input logic [31:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do
         @(negedge clock);
      while (!csr_fired);
      csr_valid <= 1'b0;
   endtask

   // Hands a span of the current container to the driver; the first byte of
   // the container carries the start flag, and noisy streams sprinkle more.
   task automatic queue_span(input int first, input int count, input bit noisy);
      req_type item;
      for (int i = first; i < first + count; i++) begin
         item.start_req = (i == 0) || (noisy && $urandom_range(0, 19) == 0);
         item.data_byte = container_bytes[i];
         byte_queue.insert(byte_queue.size(), item);
      end
   endtask

   task automatic set_mode(input int n);
      case (n % 4)
         0: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct  = 54;
            stall_pct = 0;
         end
         2: begin
            idle_pct  = 0;
            stall_pct = 54;
         end
         default: begin
            idle_pct  = 16;
            stall_pct = 16;
         end
      endcase
   endtask

   // Builds one container into container_bytes, well formed except for the
   // chosen flaw. Most tables are tiny so that streams stay short.
   task automatic build_container(input flaw_type flaw);
      int          r;
      int          ntab;
      int          ftab;
      int          nl_len;
      int          k;
      bit          stop;
      logic [31:0] count_word;
      logic [31:0] nl_word;
      logic [31:0] rows_word;
      logic [31:0] cols_word;
      container_bytes.delete();
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         add_word(MAGIC_WORD);
         r    = $urandom_range(0, 99);
         ntab = (r < 60) ? 1 : (r < 90) ? $urandom_range(2, 3) :
                (r < 97) ? $urandom_range(4, 6) : TABLE_LIMIT;
         ftab = $urandom_range(0, ntab - 1);
         count_word = ntab;
         if (flaw == FLAW_COUNT) begin
            case ($urandom_range(0, 3))
               0:       count_word = 32'd0;
               1:       count_word = TABLE_LIMIT + 1;
               2:       count_word = $urandom | 32'h20;
               default: count_word = 32'hFFFF_FFFF;
            endcase
         end
         add_word(count_word);
         stop = 1'b0;
         for (int t = 0; t < ntab && !stop; t++) begin
            if (ntab == TABLE_LIMIT)
               nl_len = 1;
            else
               nl_len = ($urandom_range(0, 9) == 0) ? NAME_LIMIT : $urandom_range(1, 5);
            nl_word = nl_len;
            if (flaw == FLAW_NLEN && t == ftab) begin
               case ($urandom_range(0, 2))
                  0:       nl_word = 32'd0;
                  1:       nl_word = NAME_LIMIT + 1;
                  default: nl_word = $urandom | 32'h80;
               endcase
               stop = 1'b1;
            end
            add_word(nl_word);
            if (!stop) begin
               repeat (nl_len) add_byte(8'($urandom_range(0, 255)));
               if (ntab == TABLE_LIMIT) begin
                  rows_word = 32'd1;
                  cols_word = 32'd1;
               end else if ($urandom_range(0, 7) == 0) begin
                  rows_word = $urandom_range(1, 8);
                  cols_word = 32'd1;
               end else begin
                  rows_word = $urandom_range(1, 3);
                  cols_word = $urandom_range(1, 3);
               end
               if (flaw == FLAW_DIMS && t == ftab) begin
                  case ($urandom_range(0, 4))
                     0: rows_word = 32'd0;
                     1: cols_word = 32'd0;
                     2: begin
                        rows_word = 32'd1025;
                        cols_word = 32'd1024;
                     end
                     3: begin
                        rows_word = 32'hFFFF_FFFF;
                        cols_word = 32'hFFFF_FFFF;
                     end
                     default: begin
                        rows_word = 32'd1 << 20;
                        cols_word = 32'd2;
                     end
                  endcase
                  stop = 1'b1;
               end
               // The largest legal tables: only the header and a few elements
               // are sent, then the next start cuts the stream short.
               if (flaw == FLAW_BIGDIM && t == ftab) begin
                  case ($urandom_range(0, 2))
                     0: begin
                        rows_word = 32'd1 << 20;
                        cols_word = 32'd1;
                     end
                     1: begin
                        rows_word = 32'd1;
                        cols_word = 32'd1 << 20;
                     end
                     default: begin
                        rows_word = 32'd1024;
                        cols_word = 32'd1024;
                     end
                  endcase
                  stop = 1'b1;
               end
               add_word(rows_word);
               add_word(cols_word);
               if (flaw == FLAW_BIGDIM && stop)
                  repeat (2 * $urandom_range(2, 6)) add_byte(8'($urandom_range(0, 255)));
               else if (!stop)
                  repeat (2 * rows_word * cols_word) add_byte(8'($urandom_range(0, 255)));
            end
         end
         // Bytes after an early verdict are dropped by the block.
         if (stop && flaw != FLAW_BIGDIM)
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
         if (flaw == FLAW_MAGIC || flaw == FLAW_CORRUPT) begin
            k = (flaw == FLAW_MAGIC) ? $urandom_range(0, 3)
                                     : $urandom_range(0, container_bytes.size() - 1);
            container_bytes[k] = container_bytes[k] ^ 8'($urandom_range(1, 255));
         end
      end
   endtask

   // Declared stream length for a container of len bytes: mostly exact, with
   // trailing room, truncation, tiny and huge values mixed in.
   function automatic logic [31:0] pick_size(input int len, input flaw_type flaw);
      int r;
      r = $urandom_range(0, 99);
      if (flaw == FLAW_BIGDIM) begin
         if (r < 50)
            return 32'hFFFF_FFFF;
         if (r < 75)
            return 32'h0020_0000 + len + $urandom_range(0, 255);
      end
      if (r < 65)
         return len;
      if (r < 77)
         return len + $urandom_range(1, 6);
      if (r < 89)
         return $urandom_range(0, len - 1);
      if (r < 94)
         return 32'hFFFF_FFFF;
      if (r < 97)
         return $urandom_range(0, 7);
      return $urandom;
   endfunction

   // Stimulus: reset, a short directed part, then random containers, each
   // with its own stream length written while no byte is in flight.
   initial begin
      int       r;
      int       len;
      int       stream_no;
      flaw_type flaw;
      req_type  stray;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero length: the start byte alone fails the magic check, and the
      // byte after the verdict is ignored.
      write_size(32'd0);
      container_bytes.delete();
      add_byte(8'h51);
      add_byte(8'h00);
      queue_span(0, 2, 1'b0);
      wait_quiet(SETTLE_CYCLES);

      // Largest length: one minimal table with all-ones name and element,
      // ending in a trailing-bytes verdict. The sender holds off mid-stream
      // until every expected result is in.
      write_size(32'hFFFF_FFFF);
      container_bytes.delete();
      add_word(MAGIC_WORD);
      add_word(32'd1);
      add_word(32'd1);
      add_byte(8'hFF);
      add_word(32'd1);
      add_word(32'd1);
      add_byte(8'hFF);
      add_byte(8'hFF);
      queue_span(0, 13, 1'b0);
      wait_quiet(0);
      queue_span(13, container_bytes.size() - 13, 1'b0);
      wait_quiet(SETTLE_CYCLES);

      stream_no = 0;
      while (parsed_items < ITEM_TARGET) begin
         set_mode(stream_no / 3);
         r    = $urandom_range(0, 99);
         flaw = (r < 50) ? FLAW_NONE : (r < 56) ? FLAW_MAGIC : (r < 62) ? FLAW_COUNT :
                (r < 68) ? FLAW_NLEN : (r < 74) ? FLAW_DIMS : (r < 77) ? FLAW_BIGDIM :
                (r < 86) ? FLAW_CORRUPT : FLAW_NOISE;
         build_container(flaw);
         len = container_bytes.size();
         write_size(pick_size(len, flaw));
         // Stray bytes ahead of the start land on an idle or finished parser,
         // or on one left mid-stream by the previous container.
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) begin
               stray.start_req = 1'b0;
               stray.data_byte = 8'($urandom_range(0, 255));
               byte_queue.insert(byte_queue.size(), stray);
            end
         end
         // Restart: part of the container, then the whole of it from a new start.
         if (flaw != FLAW_NOISE && len > 1 && $urandom_range(0, 11) == 0)
            queue_span(0, $urandom_range(1, len - 1), 1'b0);
         queue_span(0, len, flaw == FLAW_NOISE);
         wait_quiet(SETTLE_CYCLES);
         stream_no++;
      end

      wait_quiet(8);
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== qp_table_container_parser.f =====
rtl/qtp_pkg.sv
rtl/qtp_parser.sv
rtl/qtp_rsp_queue.sv
rtl/qp_table_container_parser.sv
tb/testbench.sv
